@@ src/ordered_prefix_match_table_defines.svh @@
// Assertion macros for the ordered prefix match table.
`ifndef ORDERED_PREFIX_MATCH_TABLE_DEFINES_SVH
`define ORDERED_PREFIX_MATCH_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define OPMT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define OPMT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/opmt_pkg.sv @@
// Package: constants and codes for the ordered prefix match table.
`default_nettype none
package opmt_pkg;
    localparam int DEPTH_DEF     = 256;
    localparam int KEY_WIDTH_DEF = 64;

    // Field widths
    localparam int MODE_W   = 3;
    localparam int BITS_W   = 64;
    localparam int LEN_W    = 7;
    localparam int POS_W    = 8;
    localparam int CAPREG_W = 9;
    localparam int IN_W     = 88;
    localparam int OUT_W    = 88;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 9;

    // Modes
    localparam logic [2:0] MODE_PREFIX    = 3'd0;
    localparam logic [2:0] MODE_EXACT     = 3'd1;
    localparam logic [2:0] MODE_INSERT    = 3'd2;
    localparam logic [2:0] MODE_INS_SHIFT = 3'd3;
    localparam logic [2:0] MODE_REMOVE    = 3'd4;
    localparam logic [2:0] MODE_REM_SHIFT = 3'd5;
    localparam logic [2:0] MODE_READ      = 3'd6;

    // Error codes
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_FULL  = 2'd1;
    localparam logic [1:0] ERR_WIDE  = 2'd2;
    localparam logic [1:0] ERR_RANGE = 2'd3;

    // Register indexes and reset values
    localparam logic [7:0] REG_CAPACITY = 8'd0;
    localparam logic [7:0] REG_WIDTH    = 8'd1;
    localparam logic [8:0] CAP_RESET    = 9'd256;
    localparam logic [6:0] WIDTH_RESET  = 7'd64;
endpackage
`default_nettype wire

@@ src/opmt_cell.sv @@
// One table cell: an entry register loaded from its input (the next cell, or the write-back at the tail) on each shift.
`default_nettype none
module opmt_cell #(
    parameter int KEY_WIDTH = 64
) (
    input  wire logic                 clk,
    input  wire logic                 shift_en,
    input  wire logic [KEY_WIDTH-1:0] in_bits,
    input  wire logic [6:0]           in_len,
    input  wire logic                 in_valid,
    output logic      [KEY_WIDTH-1:0] bits,
    output logic      [6:0]           len,
    output logic                      valid
);
    import opmt_pkg::*;

    logic [KEY_WIDTH-1:0] bits_reg;
    logic [LEN_W-1:0]     len_reg;
    logic                 valid_reg;

    // Entry storage, no reset: contents are defined by writes only
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            bits_reg  <= in_bits;
            len_reg   <= in_len;
            valid_reg <= in_valid;
        end
    end

    assign bits  = bits_reg;
    assign len   = len_reg;
    assign valid = valid_reg;
endmodule
`default_nettype wire

@@ src/ordered_prefix_match_table.sv @@
// Flow: the input transfer is registered, the ring turns once through the head in S_RUN,
// and the result is registered in S_DONE; a new item is accepted only back in S_IDLE.
// The result register frees the input side; a waiting result stalls only the last step.
// Reset (rst_n low, async): table empty, capacity 256, width limit 64, no result.
// Entry cells have no reset; only entries below the used count are ever examined.
`default_nettype none
module ordered_prefix_match_table #(
    parameter int DEPTH     = opmt_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = opmt_pkg::KEY_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // mode[2:0], key_bits[66:3], key_length[73:67], position[81:74], zero pad
    input  wire logic [opmt_pkg::IN_W-1:0]     s_tdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // found[0], match_index[8:1], read_bits[72:9], read_length[79:73],
    // error_code[81:80], zero pad
    output logic      [opmt_pkg::OUT_W-1:0]    m_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [opmt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [opmt_pkg::CFG_DAT_W-1:0] cfg_data,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready
);
    import opmt_pkg::*;

    `include "ordered_prefix_match_table_defines.svh"

    localparam int IW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 9) ? CW : 9;
    localparam logic [IW-1:0]   K_LAST = IW'(DEPTH - 1);
    localparam logic [CMPW-1:0] DEPTH_C = CMPW'(DEPTH);
    localparam logic [LEN_W-1:0] KW_LEN = LEN_W'(KEY_WIDTH);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

    // Chain of cells
    logic [KEY_WIDTH-1:0] c_bits  [DEPTH];
    logic [LEN_W-1:0]     c_len   [DEPTH];
    logic                 c_valid [DEPTH];
    logic [KEY_WIDTH-1:0] w_bits;
    logic [LEN_W-1:0]     w_len;
    logic                 w_valid;
    logic                 shift_en;

    // Control and result state
    state_t               state_reg;
    logic [IW-1:0]        k_reg;
    logic [CW-1:0]        used_reg;
    logic [CAPREG_W-1:0]  cap_reg;
    logic [LEN_W-1:0]     wlim_reg;
    logic [MODE_W-1:0]    mode_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [LEN_W-1:0]     slen_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [1:0]           err_reg;
    logic [KEY_WIDTH-1:0] hold_bits_reg;
    logic [LEN_W-1:0]     hold_len_reg;
    logic                 hold_valid_reg;
    logic                 hit_reg;
    logic [POS_W-1:0]     idx_reg;
    logic [KEY_WIDTH-1:0] rbits_reg;
    logic [LEN_W-1:0]     rlen_reg;
    logic                 m_valid_reg;
    logic [OUT_W-1:0]     m_data_reg;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            if (gi < DEPTH - 1)
            begin : g_mid
                opmt_cell #(.KEY_WIDTH(KEY_WIDTH)) u_cell (
                    .clk(clk), .shift_en(shift_en),
                    .in_bits(c_bits[gi+1]), .in_len(c_len[gi+1]),
                    .in_valid(c_valid[gi+1]),
                    .bits(c_bits[gi]), .len(c_len[gi]), .valid(c_valid[gi])
                );
            end
            else
            begin : g_tail
                opmt_cell #(.KEY_WIDTH(KEY_WIDTH)) u_cell (
                    .clk(clk), .shift_en(shift_en),
                    .in_bits(w_bits), .in_len(w_len), .in_valid(w_valid),
                    .bits(c_bits[gi]), .len(c_len[gi]), .valid(c_valid[gi])
                );
            end
        end
    endgenerate

    // Input field unpack and masking
    logic [MODE_W-1:0]    in_mode;
    logic [BITS_W-1:0]    in_key;
    logic [LEN_W-1:0]     in_len;
    logic [POS_W-1:0]     in_pos;
    logic [LEN_W-1:0]     in_slen;
    logic [KEY_WIDTH-1:0] in_mask;
    logic [KEY_WIDTH-1:0] in_key_m;
    assign in_mode = s_tdata[2:0];
    assign in_key  = s_tdata[66:3];
    assign in_len  = s_tdata[73:67];
    assign in_pos  = s_tdata[81:74];
    assign in_slen = (in_len > KW_LEN) ? KW_LEN : in_len;

    always_comb
    begin
        for (int b = 0; b < KEY_WIDTH; b++)
        begin
            in_mask[b] = (32'(KEY_WIDTH - 1 - b) < 32'(in_slen));
        end
    end
    assign in_key_m = in_key[BITS_W-1 -: KEY_WIDTH] & in_mask;

    // Insert checks against the current table
    logic [CMPW-1:0] cap_eff;
    logic [CMPW-1:0] used_c;
    logic [CMPW-1:0] in_pos_c;
    logic [1:0]      in_err;
    assign cap_eff  = (CMPW'(cap_reg) > DEPTH_C) ? DEPTH_C : CMPW'(cap_reg);
    assign used_c   = CMPW'(used_reg);
    assign in_pos_c = CMPW'(in_pos);

    always_comb
    begin
        in_err = ERR_OK;
        if (in_mode == MODE_INSERT || in_mode == MODE_INS_SHIFT)
        begin
            if ((used_c + CMPW'(1)) > cap_eff)
                in_err = ERR_FULL;
            else if (in_len > wlim_reg || in_len > KW_LEN)
                in_err = ERR_WIDE;
            else if (in_pos_c >= cap_eff)
                in_err = ERR_RANGE;
        end
    end

    // Head processing: the entry at cell 0 has logical index k_reg
    logic [CMPW-1:0]      k_c;
    logic [CMPW-1:0]      pos_c;
    logic [KEY_WIDTH-1:0] head_mask;
    logic                 head_hit;
    logic                 in_table;
    logic                 pos_in;
    logic                 ins_ok;

    assign k_c      = CMPW'(k_reg);
    assign pos_c    = CMPW'(pos_reg);
    assign in_table = (k_c < used_c);
    assign pos_in   = (pos_c < used_c);
    assign ins_ok   = (mode_reg == MODE_INSERT || mode_reg == MODE_INS_SHIFT)
                      && (err_reg == ERR_OK);

    always_comb
    begin
        for (int b = 0; b < KEY_WIDTH; b++)
        begin
            head_mask[b] = (32'(KEY_WIDTH - 1 - b) < 32'(c_len[0]));
        end
    end

    always_comb
    begin
        if (mode_reg == MODE_PREFIX)
            head_hit = (c_len[0] <= slen_reg) && ((key_reg & head_mask) == c_bits[0]);
        else
            head_hit = (c_len[0] == slen_reg) && (key_reg == c_bits[0]);
    end

    // Entry written back at the tail
    always_comb
    begin
        w_bits  = c_bits[0];
        w_len   = c_len[0];
        w_valid = c_valid[0];
        if (ins_ok)
        begin
            if (k_c == pos_c)
            begin
                w_bits  = key_reg;
                w_len   = len_reg;
                w_valid = 1'b1;
            end
            else if (pos_in && mode_reg == MODE_INS_SHIFT && k_c > pos_c && k_c <= used_c)
            begin
                w_bits  = hold_bits_reg;
                w_len   = hold_len_reg;
                w_valid = hold_valid_reg;
            end
            else if (!pos_in && k_c >= used_c && k_c < pos_c)
            begin
                w_bits  = '0;
                w_len   = '0;
                w_valid = 1'b0;
            end
        end
        else if (mode_reg == MODE_REMOVE && pos_in && k_c == pos_c)
        begin
            w_valid = 1'b0;
        end
        else if (mode_reg == MODE_REM_SHIFT && pos_in && k_c >= pos_c
                 && (k_c + CMPW'(1)) < used_c)
        begin
            w_bits  = c_bits[1];
            w_len   = c_len[1];
            w_valid = c_valid[1];
        end
    end

    assign shift_en = (state_reg == S_RUN);

    // Table size after the item
    logic [CW-1:0] used_next;
    always_comb
    begin
        used_next = used_reg;
        if (ins_ok)
        begin
            if (!pos_in)
                used_next = CW'(pos_c + CMPW'(1));
            else if (mode_reg == MODE_INS_SHIFT)
                used_next = CW'(used_c + CMPW'(1));
        end
        else if (mode_reg == MODE_REM_SHIFT && pos_in)
        begin
            used_next = CW'(used_c - CMPW'(1));
        end
    end

    // Result word
    logic [OUT_W-1:0] result;
    logic [BITS_W-1:0] rbits_al;
    assign rbits_al = BITS_W'(rbits_reg) << (BITS_W - KEY_WIDTH);
    assign result = {6'd0, err_reg, rlen_reg, rbits_al, idx_reg, hit_reg};

    logic out_free;
    assign out_free = !m_valid_reg || m_tready;

    // Sequencer, registers and result output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            k_reg       <= '0;
            used_reg    <= '0;
            cap_reg     <= CAP_RESET;
            wlim_reg    <= WIDTH_RESET;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            // a new result in S_DONE takes over the slot itself
            if (m_valid_reg && m_tready && state_reg != S_DONE)
                m_valid_reg <= 1'b0;

            if (cfg_valid)
            begin
                if (cfg_index == REG_CAPACITY)
                    cap_reg <= cfg_data;
                else if (cfg_index == REG_WIDTH)
                    wlim_reg <= cfg_data[LEN_W-1:0];
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        mode_reg  <= in_mode;
                        key_reg   <= in_key_m;
                        len_reg   <= in_len;
                        slen_reg  <= in_slen;
                        pos_reg   <= in_pos;
                        err_reg   <= in_err;
                        hit_reg   <= 1'b0;
                        idx_reg   <= '0;
                        rbits_reg <= '0;
                        rlen_reg  <= '0;
                        k_reg     <= '0;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    hold_bits_reg  <= c_bits[0];
                    hold_len_reg   <= c_len[0];
                    hold_valid_reg <= c_valid[0];
                    if ((mode_reg == MODE_PREFIX || mode_reg == MODE_EXACT) && !hit_reg
                        && in_table && c_valid[0] && head_hit)
                    begin
                        hit_reg <= 1'b1;
                        idx_reg <= k_c[POS_W-1:0];
                    end
                    if (mode_reg == MODE_READ && k_c == pos_c && pos_in && c_valid[0])
                    begin
                        rbits_reg <= c_bits[0];
                        rlen_reg  <= c_len[0];
                    end
                    k_reg <= k_reg + IW'(1);
                    if (k_reg == K_LAST)
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        m_data_reg  <= result;
                        m_valid_reg <= 1'b1;
                        used_reg    <= used_next;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // Checks
    `OPMT_ASSERT_NOW(a_used_bound, 1'b1, CMPW'(used_reg) <= DEPTH_C,
        "used count above depth")
    `OPMT_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, state_reg == S_RUN && k_reg == '0,
        "transfer did not start a rotation")
    `OPMT_ASSERT_NEXT(a_k_step, state_reg == S_RUN && k_reg != K_LAST,
        state_reg == S_RUN && k_reg == $past(k_reg) + IW'(1),
        "rotation index did not advance")
endmodule
`default_nettype wire
